// ===== sv/pscf_pkg.sv =====
// ----------------------------------------------------------------------------
// pscf_pkg: shared constants for the palette special color finder
// Brightness window, default picks, register indexes and field widths.
// ----------------------------------------------------------------------------
package pscf_pkg;

    localparam int GUN_W   = 8;   // one color gun
    localparam int SUM_W   = 10;  // r + g + b
    localparam int IDX_W   = 8;   // palette index on the result
    localparam int CFG_W   = 9;   // widest register (num_colors)
    localparam int CFG_IDX_W = 1;

    typedef logic [GUN_W-1:0] gun_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [IDX_W-1:0] pal_idx_t;
    typedef logic [CFG_W-1:0] cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_NUM_COLORS    = 1'b0;
    localparam cfg_idx_t REG_PALETTE_KNOWN = 1'b1;

    // reset values of the registers
    localparam cfg_data_t NUM_COLORS_RESET = 9'd256;

    // medium window: brightness strictly between these
    localparam sum_t MEDIUM_HIGH = 10'd150;
    localparam sum_t MEDIUM_LOW  = 10'd80;

    // scan start values
    localparam sum_t     DARK_START     = 10'd1023;
    localparam pal_idx_t DEFAULT_DARK   = 8'd0;
    localparam pal_idx_t DEFAULT_MEDIUM = 8'd7;
    localparam pal_idx_t DEFAULT_BRIGHT = 8'd15;

    // fixed picks for a two-color palette
    localparam cfg_data_t TWO_COLORS    = 9'd2;
    localparam pal_idx_t  TWO_MEDIUM    = 8'd1;
    localparam pal_idx_t  TWO_BRIGHT    = 8'd1;

endpackage

// ===== sv/palette_special_color_finder.sv =====
// ----------------------------------------------------------------------------
// palette_special_color_finder
// Scans a palette stream and reports darkest, medium and brightest entries.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) carries one palette entry per
//   request, red/green/blue, entry 0 first. After the last entry of a scan
//   (num_colors entries, clamped to 2..MAX_COLORS) one request goes out on
//   the result channel (result_valid/result_ready) with dark_index,
//   medium_index and bright_index; other entries produce nothing.
//   Throughput: one entry per cycle while the result channel does not hold a
//   last entry back. Each entry is first held in the input register, then a
//   single pass of adds/compares updates the running picks and, for the
//   last entry, loads the result register, which drives result_valid.
//   Config: cfg_we/cfg_index/cfg_data write num_colors (0) or
//   palette_known (1); write only while idle.
//   Reset: num_colors = 256, palette_known = 1, scan restarts at entry 0,
//   no result pending. If the result receiver stalls, a last entry waits
//   in the input register; ordinary entries keep flowing until then.
// ----------------------------------------------------------------------------
module palette_special_color_finder #(
    parameter int MAX_COLORS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  pscf_pkg::cfg_idx_t   cfg_index,
    input  pscf_pkg::cfg_data_t  cfg_data,
    // palette entries
    input  logic                 item_valid,
    output logic                 item_ready,
    input  pscf_pkg::gun_t       red,
    input  pscf_pkg::gun_t       green,
    input  pscf_pkg::gun_t       blue,
    // results
    output logic                 result_valid,
    input  logic                 result_ready,
    output pscf_pkg::pal_idx_t   dark_index,
    output pscf_pkg::pal_idx_t   medium_index,
    output pscf_pkg::pal_idx_t   bright_index
);
    import pscf_pkg::*;

    localparam int CNT_W = (MAX_COLORS > 2) ? $clog2(MAX_COLORS) : 1;
    localparam cfg_data_t MAX_LEN = cfg_data_t'(MAX_COLORS);

    // configuration registers
    cfg_data_t num_colors_reg;
    logic      palette_known_reg;

    // input register
    logic      in_valid_reg;
    gun_t      red_reg, green_reg, blue_reg;

    // scan state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    sum_t      best_bright_reg, best_bright_next;
    sum_t      best_dark_reg, best_dark_next;
    sum_t      best_med_reg, best_med_next;
    pal_idx_t  dark_pick_reg, dark_pick_next;
    pal_idx_t  med_pick_reg, med_pick_next;
    pal_idx_t  bright_pick_reg, bright_pick_next;

    // result register
    logic      out_valid_reg;
    pal_idx_t  dark_out_reg, med_out_reg, bright_out_reg;
    pal_idx_t  dark_out_next, med_out_next, bright_out_next;

    // per-entry values
    cfg_data_t scan_len;
    pal_idx_t  idx;
    sum_t      brt;
    gun_t      gun_hi, gun_lo;
    sum_t      score;
    logic      in_window;
    logic      is_last;
    logic      fire;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg    <= NUM_COLORS_RESET;
            palette_known_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_COLORS:    num_colors_reg    <= cfg_data;
                REG_PALETTE_KNOWN: palette_known_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // scan length clamped to 2..MAX_COLORS
    always_comb
    begin
        if (num_colors_reg < TWO_COLORS)
            scan_len = TWO_COLORS;
        else if (num_colors_reg > MAX_LEN)
            scan_len = MAX_LEN;
        else
            scan_len = num_colors_reg;
    end

    // handshake: a last entry needs a free result slot
    assign idx     = pal_idx_t'(cnt_reg);
    assign is_last = !((cfg_data_t'(cnt_reg) + 9'd1) < scan_len);
    assign fire    = in_valid_reg && (!is_last || !out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    // brightness, gun spread, medium score
    always_comb
    begin
        brt    = sum_t'(red_reg) + sum_t'(green_reg) + sum_t'(blue_reg);
        gun_hi = red_reg;
        gun_lo = red_reg;
        if (green_reg > gun_hi) gun_hi = green_reg;
        if (green_reg < gun_lo) gun_lo = green_reg;
        if (blue_reg > gun_hi)  gun_hi = blue_reg;
        if (blue_reg < gun_lo)  gun_lo = blue_reg;
        score     = brt - sum_t'((gun_hi - gun_lo) >> 1);
        in_window = (brt < MEDIUM_HIGH) && (brt > MEDIUM_LOW);
    end

    // running picks; first entry wins ties (strict compares)
    always_comb
    begin
        best_bright_next = best_bright_reg;
        bright_pick_next = bright_pick_reg;
        best_dark_next   = best_dark_reg;
        dark_pick_next   = dark_pick_reg;
        best_med_next    = best_med_reg;
        med_pick_next    = med_pick_reg;
        if (brt > best_bright_reg)
        begin
            best_bright_next = brt;
            bright_pick_next = idx;
        end
        if (brt < best_dark_reg)
        begin
            best_dark_next = brt;
            dark_pick_next = idx;
        end
        if (in_window && (score > best_med_reg))
        begin
            best_med_next = score;
            med_pick_next = idx;
        end
        cnt_next = cnt_reg + 1'b1;
    end

    // result selection for the last entry
    always_comb
    begin
        if (scan_len == TWO_COLORS)
        begin
            dark_out_next   = DEFAULT_DARK;
            med_out_next    = TWO_MEDIUM;
            bright_out_next = TWO_BRIGHT;
        end
        else if (!palette_known_reg)
        begin
            dark_out_next   = DEFAULT_DARK;
            med_out_next    = DEFAULT_MEDIUM;
            bright_out_next = DEFAULT_BRIGHT;
        end
        else
        begin
            dark_out_next   = dark_pick_next;
            med_out_next    = med_pick_next;
            bright_out_next = bright_pick_next;
        end
    end

    // scan state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            best_bright_reg <= '0;
            best_dark_reg   <= DARK_START;
            best_med_reg    <= '0;
            dark_pick_reg   <= DEFAULT_DARK;
            med_pick_reg    <= DEFAULT_MEDIUM;
            bright_pick_reg <= DEFAULT_BRIGHT;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                cnt_reg         <= '0;
                best_bright_reg <= '0;
                best_dark_reg   <= DARK_START;
                best_med_reg    <= '0;
                dark_pick_reg   <= DEFAULT_DARK;
                med_pick_reg    <= DEFAULT_MEDIUM;
                bright_pick_reg <= DEFAULT_BRIGHT;
            end
            else
            begin
                cnt_reg         <= cnt_next;
                best_bright_reg <= best_bright_next;
                best_dark_reg   <= best_dark_next;
                best_med_reg    <= best_med_next;
                dark_pick_reg   <= dark_pick_next;
                med_pick_reg    <= med_pick_next;
                bright_pick_reg <= bright_pick_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && is_last)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_last)
        begin
            dark_out_reg   <= dark_out_next;
            med_out_reg    <= med_out_next;
            bright_out_reg <= bright_out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign dark_index   = dark_out_reg;
    assign medium_index = med_out_reg;
    assign bright_index = bright_out_reg;

    // checks
    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last) |=> (cnt_reg == '0) && result_valid)
        else $error("scan did not restart after last entry");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_data_t'(cnt_reg) < MAX_LEN)
        else $error("entry counter beyond palette size");

    a_two_colors: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last && (scan_len == TWO_COLORS)) |=>
        (medium_index == TWO_MEDIUM) && (bright_index == TWO_BRIGHT)
        && (dark_index == DEFAULT_DARK))
        else $error("two-color result wrong");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (in_valid_reg && is_last && out_valid_reg && !result_ready))
        else $error("input stalled without a blocked result");

endmodule

// ===== dv/tb_palette_special_color_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_special_color_finder: self-checking bench for the finder
// Streams palette entries through the item channel and predicts the dark,
// medium and bright picks of every finished scan in a local model. Each
// result request is checked field by field against the oldest prediction.
// A short directed part covers the window edges, ties, the two-color and
// unknown-palette picks, length clamping and a length change mid-scan. It
// is followed by random phases with varied lengths, random idle bursts on
// both channels and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_palette_special_color_finder;
    import pscf_pkg::*;

    localparam int PALETTE_MAX     = 256;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_ITEMS    = 1400;

    typedef struct packed {
        gun_t red;
        gun_t green;
        gun_t blue;
    } entry_t;

    typedef struct packed {
        pal_idx_t dark;
        pal_idx_t mid;
        pal_idx_t bright;
    } picks_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      cfg_we       = 1'b0;
    cfg_idx_t  cfg_index    = REG_NUM_COLORS;
    cfg_data_t cfg_data     = '0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    gun_t      red          = '0;
    gun_t      green        = '0;
    gun_t      blue         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    pal_idx_t  dark_index;
    pal_idx_t  medium_index;
    pal_idx_t  bright_index;

    palette_special_color_finder #(
        .MAX_COLORS(PALETTE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .red(red),
        .green(green),
        .blue(blue),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .dark_index(dark_index),
        .medium_index(medium_index),
        .bright_index(bright_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model of the scan: running picks and register copies
    pal_idx_t  scan_pos;
    sum_t      top_sum;
    sum_t      low_sum;
    sum_t      grey_score;
    pal_idx_t  low_pick;
    pal_idx_t  grey_pick;
    pal_idx_t  top_pick;
    cfg_data_t model_len   = NUM_COLORS_RESET;
    logic      model_known = 1'b1;

    entry_t entries_todo[$];
    picks_t picks_due[$];
    entry_t next_entry;
    picks_t want;

    int errors      = 0;
    int stall_count = 0;
    int send_gap    = 0;
    int take_gap    = 0;
    int hold_left   = 0;
    bit idle_on     = 1'b0;
    bit hold_req    = 1'b0;
    bit entry_offered = 1'b0;
    bit handshake;

    task automatic restart_scan();
        scan_pos   = '0;
        top_sum    = '0;
        low_sum    = DARK_START;
        grey_score = '0;
        low_pick   = DEFAULT_DARK;
        grey_pick  = DEFAULT_MEDIUM;
        top_pick   = DEFAULT_BRIGHT;
    endtask

    // fold one accepted entry into the running picks
    task automatic scan_entry(entry_t e);
        sum_t   brt;
        sum_t   score;
        gun_t   hi;
        gun_t   lo;
        gun_t   spread;
        int     len;
        picks_t picks;
        brt = sum_t'(e.red) + sum_t'(e.green) + sum_t'(e.blue);
        len = int'(model_len);
        if (len < 2)
            len = 2;
        if (len > PALETTE_MAX)
            len = PALETTE_MAX;
        if (brt > top_sum)
        begin
            top_sum  = brt;
            top_pick = scan_pos;
        end
        if (brt < low_sum)
        begin
            low_sum  = brt;
            low_pick = scan_pos;
        end
        // medium candidates: inside the open window, penalized by gun spread
        if (brt < MEDIUM_HIGH && brt > MEDIUM_LOW)
        begin
            hi = e.red;
            lo = e.red;
            if (e.green > hi) hi = e.green;
            if (e.green < lo) lo = e.green;
            if (e.blue > hi) hi = e.blue;
            if (e.blue < lo) lo = e.blue;
            spread = hi - lo;
            score  = brt - sum_t'(spread >> 1);
            if (score > grey_score)
            begin
                grey_score = score;
                grey_pick  = scan_pos;
            end
        end
        if (int'(scan_pos) + 1 < len)
            scan_pos = scan_pos + 1'b1;
        else
        begin
            if (len == 2)
                picks = '{DEFAULT_DARK, TWO_MEDIUM, TWO_BRIGHT};
            else if (!model_known)
                picks = '{DEFAULT_DARK, DEFAULT_MEDIUM, DEFAULT_BRIGHT};
            else
                picks = '{low_pick, grey_pick, top_pick};
            picks_due.push_back(picks);
            restart_scan();
        end
    endtask

    function automatic void check_field(string name, pal_idx_t exp_val, pal_idx_t got);
        if (got !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got);
            errors++;
        end
    endfunction

    // item driver: one entry per request, random idle bursts
    always @(negedge clk)
    begin
        if (rst_n && !entry_offered)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(0, 18);
                item_valid <= 1'b0;
            end
            else if (entries_todo.size() > 0)
            begin
                next_entry = entries_todo.pop_front();
                red   <= next_entry.red;
                green <= next_entry.green;
                blue  <= next_entry.blue;
                item_valid <= 1'b1;
                entry_offered = 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver: long hold-off on request, otherwise random bursts
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            take_gap = $urandom_range(0, 18);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // monitor: predict on accepted entries, check results, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            handshake = 1'b0;
            if (item_valid && item_ready)
            begin
                scan_entry({red, green, blue});
                entry_offered = 1'b0;
                handshake = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                handshake = 1'b1;
                if (picks_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, dark_index, medium_index, bright_index);
                    errors++;
                end
                else
                begin
                    want = picks_due.pop_front();
                    check_field("dark_index", want.dark, dark_index);
                    check_field("medium_index", want.mid, medium_index);
                    check_field("bright_index", want.bright, bright_index);
                end
            end
            if (handshake)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_NUM_COLORS)
            model_len = val;
        else
            model_known = val[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_entry(int r, int g, int b);
        entries_todo.push_back('{gun_t'(r), gun_t'(g), gun_t'(b)});
    endtask

    // wait until all entries are in and all results out, then let it drain
    task automatic settle();
        while (entries_todo.size() > 0 || entry_offered || picks_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic entry_t random_entry();
        entry_t e;
        int     g;
        case ($urandom_range(0, 4))
            0: e = '{gun_t'($urandom), gun_t'($urandom), gun_t'($urandom)};
            1:
            begin
                g = $urandom_range(24, 52);
                e = '{gun_t'(g), gun_t'(g), gun_t'(g)};
            end
            2: e = '{gun_t'($urandom_range(10, 70)), gun_t'($urandom_range(10, 70)),
                     gun_t'($urandom_range(10, 70))};
            3: e = '{$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                     $urandom_range(0, 1) ? 8'hFF : 8'h00};
            default: e = '{gun_t'($urandom_range(0, 3)), gun_t'($urandom_range(0, 3)),
                           gun_t'($urandom_range(0, 3))};
        endcase
        return e;
    endfunction

    initial
    begin
        int len;
        int eff;
        int count;
        int phase;
        int random_sent;
        int big_left;
        bit known;
        bit calm;
        restart_scan();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of the guns, one of each pick
        write_reg(REG_NUM_COLORS, 9'd4);
        write_reg(REG_PALETTE_KNOWN, 9'd1);
        push_entry(0, 0, 0);
        push_entry(255, 255, 255);
        push_entry(40, 40, 40);
        push_entry(255, 0, 0);
        settle();
        // two colors: fixed picks whatever the entries
        write_reg(REG_NUM_COLORS, TWO_COLORS);
        push_entry(255, 255, 255);
        push_entry(0, 0, 0);
        settle();
        // palette unknown gives the defaults
        write_reg(REG_NUM_COLORS, 9'd3);
        write_reg(REG_PALETTE_KNOWN, 9'd0);
        push_entry(10, 200, 30);
        push_entry(90, 20, 5);
        push_entry(1, 2, 3);
        settle();
        // all black: no bright and no medium entry, defaults beyond the scan
        write_reg(REG_PALETTE_KNOWN, 9'd1);
        repeat (3) push_entry(0, 0, 0);
        settle();
        // medium window edges (80, 150 out; 81, 149 in) and a tie
        write_reg(REG_NUM_COLORS, 9'd5);
        push_entry(27, 27, 26);
        push_entry(50, 50, 50);
        push_entry(27, 27, 27);
        push_entry(50, 50, 49);
        push_entry(50, 50, 49);
        settle();
        // length below range acts as two
        write_reg(REG_NUM_COLORS, 9'd0);
        push_entry(3, 4, 5);
        push_entry(200, 1, 1);
        settle();
        // length above range, then shrunk mid-scan: next entry ends the scan
        write_reg(REG_NUM_COLORS, 9'd511);
        repeat (6) entries_todo.push_back(random_entry());
        settle();
        write_reg(REG_NUM_COLORS, 9'd4);
        push_entry(128, 64, 32);
        settle();

        // random phases; the stall phase always runs
        random_sent = 0;
        phase = 0;
        big_left = 3;
        while (random_sent < RANDOM_ITEMS || phase <= 4)
        begin
            calm = random_sent > (RANDOM_ITEMS * 85) / 100;
            case ($urandom_range(0, 15))
                0: len = $urandom_range(0, 1);
                1:
                begin
                    if (big_left > 0)
                    begin
                        big_left--;
                        len = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                    end
                    else
                        len = $urandom_range(2, 8);
                end
                2, 3: len = $urandom_range(17, 64);
                default: len = $urandom_range(2, 16);
            endcase
            known = $urandom_range(0, 4) != 0;
            if (phase == 4)
            begin
                len = 2;
                known = 1'b1;
            end
            write_reg(REG_NUM_COLORS, cfg_data_t'(len));
            write_reg(REG_PALETTE_KNOWN, cfg_data_t'(known));
            eff = (len < 2) ? 2 : (len > PALETTE_MAX) ? PALETTE_MAX : len;
            count = eff * ((eff > 64) ? 1 : $urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, eff - 1);
            if (phase == 4)
                count = 80;
            idle_on = !calm && phase != 4 && $urandom_range(0, 3) != 0;
            repeat (count) entries_todo.push_back(random_entry());
            // long result stall backs the block up into its input
            if (phase == 4)
                hold_req = 1'b1;
            random_sent += count;
            phase++;
            settle();
        end

        idle_on = 1'b0;
        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && picks_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
